>>> hw/rtl/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants for the keyframe track sampler.
// ----------------------------------------------------------------------------
package kts_pkg;

  // Configuration register indexes
  localparam logic [2:0] RegLoopEnable   = 3'd0;
  localparam logic [2:0] RegClipDuration = 3'd1;
  localparam logic [2:0] RegKeyCount     = 3'd2;
  localparam logic [2:0] RegDefaultX     = 3'd3;
  localparam logic [2:0] RegDefaultY     = 3'd4;
  localparam logic [2:0] RegDefaultZ     = 3'd5;

  // Input command codes
  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdSample = 1'b1;

  // Remainder steps for the time wrap, quotient steps for alpha
  localparam logic [5:0] ModSteps   = 6'd32;
  localparam logic [5:0] AlphaSteps = 6'd16;

  localparam logic [15:0] AlphaMax = 16'hFFFF;

  // One stored keyframe
  typedef struct packed {
    logic [31:0] ktime;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } key_t;

  // Request to the shared divider
  typedef struct packed {
    logic        start;
    logic [31:0] rem_init;
    logic [31:0] dividend;
    logic [31:0] divisor;
    logic [5:0]  steps;
  } div_req_t;

  // Divider result
  typedef struct packed {
    logic        done;
    logic [31:0] rem;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

>>> hw/rtl/keyframe_track_sampler.sv
// ----------------------------------------------------------------------------
// keyframe_track_sampler
// Keyframe track with linear interpolation over a table of Q16.16 keys.
// A key write goes straight to the table; a sample on an empty table
// emits the defaults, else it runs time wrap, binary search and blend.
// The wrap (32 steps) and alpha (16 steps) share one serial divider; each
// search probe passes the search and compare states on the single table read port.
// One item at a time; reset clears control state and configuration.
// ----------------------------------------------------------------------------
module keyframe_track_sampler #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [5:0]  key_index_i,
  input  logic [31:0] key_time_i,
  input  logic [31:0] key_x_i,
  input  logic [31:0] key_y_i,
  input  logic [31:0] key_z_i,
  input  logic [31:0] sample_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o
);

  localparam int unsigned Aw = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned Cw = $clog2(MAX_KEYS + 1);
  localparam logic [Cw-1:0] MaxN = Cw'(MAX_KEYS);

  typedef enum logic [3:0] {
    StIdle, StMap, StWaitMod, StRdFirst, StChkFirst, StChkLast, StSearch,
    StCmp, StLoadRes, StRdUp, StRdLo, StSpan, StWaitAlpha, StMul, StAdd, StEmit
  } state_e;

  state_e state_q;

  // Configuration
  logic        loop_q;
  logic [30:0] dur_q;
  logic [6:0]  kcount_q;
  logic [31:0] def_x_q, def_y_q, def_z_q;

  // Working registers
  logic [Cw-1:0]      n_q, first_q, len_q;
  logic [Aw-1:0]      mid_q;
  logic [31:0]        st_q;
  logic signed [32:0] t_q;
  kts_pkg::key_t      ku_q, kl_q;
  logic [15:0]        alpha_q;
  logic [1:0]         comp_q;
  logic signed [49:0] prod_q;
  logic [31:0]        res_q [3];
  logic               out_valid_q;
  logic [31:0]        out_x_q, out_y_q, out_z_q;

  // Table and divider wiring
  logic               ram_we;
  logic [Aw-1:0]      ram_waddr, ram_raddr;
  logic [31:0]        kidx_ext;
  kts_pkg::key_t      ram_wdata, ram_rdata;
  kts_pkg::div_req_t  div_req;
  kts_pkg::div_rsp_t  div_rsp;

  logic               accept;
  logic [Cw-1:0]      n_eff, half, last_n;
  logic [Aw-1:0]      mid;
  logic signed [32:0] rd_time, tl_s, span, num;
  logic [31:0]        st_mag;
  logic signed [32:0] blend_lo, blend_hi, blend_diff;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);

  // Key writes go straight to the table
  assign kidx_ext  = 32'(key_index_i);
  assign ram_we    = accept && (cmd_i == kts_pkg::CmdWrite) && (kidx_ext < MAX_KEYS);
  assign ram_waddr = kidx_ext[Aw-1:0];
  assign ram_wdata = '{ktime: key_time_i, x: key_x_i, y: key_y_i, z: key_z_i};

  assign n_eff   = (32'(kcount_q) > MAX_KEYS) ? MaxN : Cw'(kcount_q);
  assign half    = len_q >> 1;
  assign mid     = Aw'(first_q + half);
  assign last_n  = n_q - Cw'(1);
  assign rd_time = {ram_rdata.ktime[31], ram_rdata.ktime};
  assign tl_s    = {kl_q.ktime[31], kl_q.ktime};
  assign span    = {ku_q.ktime[31], ku_q.ktime} - tl_s;
  assign num     = t_q - tl_s;
  assign st_mag  = st_q[31] ? (~st_q + 32'd1) : st_q;

  // Table read address per state
  always_comb begin
    ram_raddr = '0;
    case (state_q)
      StChkFirst: ram_raddr = Aw'(last_n);
      StSearch: begin
        if (len_q != '0) begin
          ram_raddr = mid;
        end else if (first_q >= n_q) begin
          ram_raddr = Aw'(last_n);
        end else begin
          ram_raddr = Aw'(first_q);
        end
      end
      StRdUp:  ram_raddr = Aw'(first_q - Cw'(1));
      default: ram_raddr = '0;
    endcase
  end

  // Divider requests: time wrap or alpha quotient
  always_comb begin
    div_req = '0;
    if (state_q == StMap && loop_q && dur_q != '0) begin
      div_req.start    = 1'b1;
      div_req.rem_init = '0;
      div_req.dividend = st_mag;
      div_req.divisor  = {1'b0, dur_q};
      div_req.steps    = kts_pkg::ModSteps;
    end else if (state_q == StSpan && span > 0 && num > 0 && num < span) begin
      div_req.start    = 1'b1;
      div_req.rem_init = num[31:0];
      div_req.dividend = '0;
      div_req.divisor  = span[31:0];
      div_req.steps    = kts_pkg::AlphaSteps;
    end
  end

  // Component selected for the blend
  always_comb begin
    case (comp_q)
      2'd0: begin
        blend_lo = {kl_q.x[31], kl_q.x};
        blend_hi = {ku_q.x[31], ku_q.x};
      end
      2'd1: begin
        blend_lo = {kl_q.y[31], kl_q.y};
        blend_hi = {ku_q.y[31], ku_q.y};
      end
      default: begin
        blend_lo = {kl_q.z[31], kl_q.z};
        blend_hi = {ku_q.z[31], ku_q.z};
      end
    endcase
    blend_diff = blend_hi - blend_lo;
  end

  kts_key_ram #(.Depth(MAX_KEYS), .Aw(Aw)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  kts_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q   <= 1'b0;
      dur_q    <= '0;
      kcount_q <= '0;
      def_x_q  <= '0;
      def_y_q  <= '0;
      def_z_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kts_pkg::RegLoopEnable:   loop_q   <= cfg_wdata_i[0];
        kts_pkg::RegClipDuration: dur_q    <= cfg_wdata_i[30:0];
        kts_pkg::RegKeyCount:     kcount_q <= cfg_wdata_i[6:0];
        kts_pkg::RegDefaultX:     def_x_q  <= cfg_wdata_i;
        kts_pkg::RegDefaultY:     def_y_q  <= cfg_wdata_i;
        kts_pkg::RegDefaultZ:     def_z_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer with its registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      first_q     <= '0;
      len_q       <= '0;
      mid_q       <= '0;
      comp_q      <= '0;
    end else begin
      // Emit state refills the output register itself
      if (out_valid_q && out_ready_i && state_q != StEmit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept && cmd_i == kts_pkg::CmdSample) begin
            st_q <= sample_time_i;
            n_q  <= n_eff;
            if (n_eff == '0) begin
              res_q[0] <= def_x_q;
              res_q[1] <= def_y_q;
              res_q[2] <= def_z_q;
              state_q  <= StEmit;
            end else begin
              state_q <= StMap;
            end
          end
        end
        StMap: begin
          if (dur_q == '0) begin
            t_q     <= '0;
            state_q <= StRdFirst;
          end else if (loop_q) begin
            state_q <= StWaitMod;
          end else begin
            if (st_q[31]) begin
              t_q <= '0;
            end else if (st_q > {1'b0, dur_q}) begin
              t_q <= {2'b00, dur_q};
            end else begin
              t_q <= {1'b0, st_q};
            end
            state_q <= StRdFirst;
          end
        end
        StWaitMod: begin
          if (div_rsp.done) begin
            if (st_q[31] && div_rsp.rem != '0) begin
              t_q <= 33'({1'b0, dur_q}) - 33'(div_rsp.rem);
            end else begin
              t_q <= 33'(div_rsp.rem);
            end
            state_q <= StRdFirst;
          end
        end
        StRdFirst: state_q <= StChkFirst;
        StChkFirst: begin
          if (n_q == Cw'(1) || t_q <= rd_time) begin
            res_q[0] <= ram_rdata.x;
            res_q[1] <= ram_rdata.y;
            res_q[2] <= ram_rdata.z;
            state_q  <= StEmit;
          end else begin
            state_q <= StChkLast;
          end
        end
        StChkLast: begin
          if (t_q >= rd_time) begin
            res_q[0] <= ram_rdata.x;
            res_q[1] <= ram_rdata.y;
            res_q[2] <= ram_rdata.z;
            state_q  <= StEmit;
          end else begin
            first_q <= '0;
            len_q   <= n_q;
            state_q <= StSearch;
          end
        end
        StSearch: begin
          if (len_q != '0) begin
            mid_q   <= mid;
            state_q <= StCmp;
          end else if (first_q == '0 || first_q >= n_q) begin
            state_q <= StLoadRes;
          end else begin
            state_q <= StRdUp;
          end
        end
        StCmp: begin
          if (!(t_q < rd_time)) begin
            first_q <= Cw'(mid_q) + Cw'(1);
            len_q   <= len_q - half - Cw'(1);
          end else begin
            len_q <= half;
          end
          state_q <= StSearch;
        end
        StLoadRes: begin
          res_q[0] <= ram_rdata.x;
          res_q[1] <= ram_rdata.y;
          res_q[2] <= ram_rdata.z;
          state_q  <= StEmit;
        end
        StRdUp: begin
          ku_q    <= ram_rdata;
          state_q <= StRdLo;
        end
        StRdLo: begin
          kl_q    <= ram_rdata;
          state_q <= StSpan;
        end
        StSpan: begin
          comp_q <= '0;
          if (span <= 0) begin
            res_q[0] <= ku_q.x;
            res_q[1] <= ku_q.y;
            res_q[2] <= ku_q.z;
            state_q  <= StEmit;
          end else if (num <= 0) begin
            alpha_q <= '0;
            state_q <= StMul;
          end else if (num >= span) begin
            alpha_q <= kts_pkg::AlphaMax;
            state_q <= StMul;
          end else begin
            state_q <= StWaitAlpha;
          end
        end
        StWaitAlpha: begin
          if (div_rsp.done) begin
            alpha_q <= div_rsp.quot[15:0];
            state_q <= StMul;
          end
        end
        StMul: begin
          prod_q  <= blend_diff * $signed({1'b0, alpha_q});
          state_q <= StAdd;
        end
        StAdd: begin
          // arithmetic shift floors toward minus infinity
          res_q[comp_q] <= 32'(blend_lo + 33'(prod_q >>> 16));
          if (comp_q == 2'd2) begin
            state_q <= StEmit;
          end else begin
            comp_q  <= comp_q + 2'd1;
            state_q <= StMul;
          end
        end
        StEmit: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_x_q     <= res_q[0];
            out_y_q     <= res_q[1];
            out_z_q     <= res_q[2];
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;

`ifndef SYNTHESIS
  // Divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == StWaitMod || state_q == StWaitAlpha))
    else $error("divider done outside a wait state");

  // Search window never exceeds the key count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearch) |-> (32'(first_q) + 32'(len_q) <= 32'(n_q)))
    else $error("search window out of range");

  // A finished sample always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("result lost at emit");

  // A write never occupies the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == kts_pkg::CmdWrite) |=> (state_q == StIdle))
    else $error("key write left idle");
`endif

endmodule

>>> hw/rtl/kts_divider.sv
// ----------------------------------------------------------------------------
// kts_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kts_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kts_pkg::div_req_t  req_i,
  output kts_pkg::div_rsp_t  rsp_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] div_q;
  logic        done_q;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        take;

  // One compare-and-subtract step
  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, div_q};
  assign take  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      quo_q <= req_i.dividend;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= take ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[30:0], take};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;
  assign rsp_o.quot = quo_q;

endmodule

>>> hw/rtl/kts_key_ram.sv
// ----------------------------------------------------------------------------
// kts_key_ram
// Keyframe table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kts_key_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Aw    = 6
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [Aw-1:0]      waddr_i,
  input  kts_pkg::key_t      wdata_i,
  input  logic [Aw-1:0]      raddr_i,
  output kts_pkg::key_t      rdata_o
);

  kts_pkg::key_t mem [Depth];
  kts_pkg::key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
